// ===== src/assert_macros.svh =====
// assertion helpers for the rtl sequencer (okl_ctrl)
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define OKL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define OKL_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/okl_pkg.sv =====
// ----------------------------------------------------------------------------
// okl_pkg
// Types and codes shared by the ordered key list cells, control and top level.
// ----------------------------------------------------------------------------
package okl_pkg;

  localparam int KEY_W = 32;
  localparam int LEN_W = 5;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_DUMP = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [KEY_W-1:0] key_in;
  } in_req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] key_out;
    logic                    last;
    logic [LEN_W-1:0]        length;
  } out_rsp_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                    append_en;
    logic                    delete_en;
    logic                    rotate_en;
    logic signed [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

// ===== src/ordered_key_list_append_delete.sv =====
// ----------------------------------------------------------------------------
// ordered_key_list_append_delete
// Append and delete give their result in the cycle after the request.
// Dump rotates the keys out of the cell chain one key per cycle, the first
// in the cycle after the request; an empty dump gives a single empty result.
// Reset clears the fill count and sequencer; cell contents are not reset.
// Results are strobed by out_valid for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module ordered_key_list_append_delete #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  okl_pkg::in_req_t  in_req,
  output logic              out_valid,
  output okl_pkg::out_rsp_t out_rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  okl_pkg::cell_ctl_t               ctl;
  logic [CW-1:0]                    cnt;
  logic [DEPTH:0]                   hit;
  logic signed [okl_pkg::KEY_W-1:0] key_q [DEPTH];

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [okl_pkg::KEY_W-1:0] next_key;
    if (i == DEPTH - 1) begin : g_end
      assign next_key = '0;
    end else begin : g_mid
      assign next_key = key_q[i+1];
    end

    okl_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cnt      (cnt),
      .hit_in   (hit[i]),
      .hit_out  (hit[i+1]),
      .next_key (next_key),
      .wrap_key (key_q[0]),
      .key_q    (key_q[i])
    );
  end

  okl_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .found     (hit[DEPTH]),
    .head_key  (key_q[0]),
    .busy      (busy),
    .ctl       (ctl),
    .cnt       (cnt),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

// ===== src/okl_cell.sv =====
// ----------------------------------------------------------------------------
// okl_cell
// One slot of the key list: holds a key, compares it, shifts toward the head.
// ----------------------------------------------------------------------------
module okl_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  okl_pkg::cell_ctl_t              ctl,
  input  logic [CW-1:0]                   cnt,
  input  logic                            hit_in,
  output logic                            hit_out,
  input  logic signed [okl_pkg::KEY_W-1:0] next_key,
  input  logic signed [okl_pkg::KEY_W-1:0] wrap_key,
  output logic signed [okl_pkg::KEY_W-1:0] key_q
);

  logic signed [okl_pkg::KEY_W-1:0] key_r;
  logic signed [okl_pkg::KEY_W-1:0] key_nxt;
  logic                             occupied;
  logic                             is_tail;
  logic                             is_free_slot;
  logic                             match;

  assign occupied     = CW'(IDX) < cnt;
  assign is_tail      = cnt == CW'(IDX + 1);
  assign is_free_slot = cnt == CW'(IDX);
  assign match        = occupied && (key_r == ctl.key);
  // first match and everything behind it moves up one slot
  assign hit_out      = hit_in | match;

  always_comb begin
    key_nxt = key_r;
    priority if (ctl.append_en && is_free_slot) begin
      key_nxt = ctl.key;
    end else if (ctl.delete_en && hit_out) begin
      key_nxt = next_key;
    end else if (ctl.rotate_en && occupied) begin
      // tail takes the head so the list comes back in order after a full pass
      key_nxt = is_tail ? wrap_key : next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q = key_r;

endmodule

// ===== src/okl_ctrl.sv =====
// ----------------------------------------------------------------------------
// okl_ctrl
// Sequencer: decodes requests, keeps the fill count, drives the result port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module okl_ctrl #(
  parameter int DEPTH = 16,
  parameter int CW    = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  okl_pkg::in_req_t                 in_req,
  input  logic                             found,
  input  logic signed [okl_pkg::KEY_W-1:0] head_key,
  output logic                             busy,
  output okl_pkg::cell_ctl_t               ctl,
  output logic [CW-1:0]                    cnt,
  output logic                             out_valid,
  output okl_pkg::out_rsp_t                out_rsp
);

  okl_pkg::fsm_t     state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  okl_pkg::out_rsp_t out_rsp_r, out_rsp_nxt;
  logic              accept;
  logic              known_cmd;

  assign accept = start && (state_r == okl_pkg::FSM_IDLE);

  assign known_cmd = (in_req.command == okl_pkg::CMD_APPEND) ||
                     (in_req.command == okl_pkg::CMD_DELETE) ||
                     (in_req.command == okl_pkg::CMD_DUMP);

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    out_valid_nxt   = 1'b0;
    out_rsp_nxt     = out_rsp_r;
    ctl.append_en   = 1'b0;
    ctl.delete_en   = 1'b0;
    ctl.rotate_en   = 1'b0;
    ctl.key         = in_req.key_in;

    unique case (state_r)
      okl_pkg::FSM_IDLE: begin
        if (start) begin
          out_rsp_nxt.key_out = '0;
          out_rsp_nxt.last    = 1'b1;
          unique case (in_req.command)
            okl_pkg::CMD_APPEND: begin
              out_valid_nxt = 1'b1;
              if (cnt_r == CW'(DEPTH)) begin
                out_rsp_nxt.status = okl_pkg::ST_FULL;
              end else begin
                ctl.append_en      = 1'b1;
                cnt_nxt            = cnt_r + CW'(1);
                out_rsp_nxt.status = okl_pkg::ST_OK;
              end
            end
            okl_pkg::CMD_DELETE: begin
              // cells only shift when a match exists
              ctl.delete_en = 1'b1;
              out_valid_nxt = 1'b1;
              if (found) begin
                cnt_nxt            = cnt_r - CW'(1);
                out_rsp_nxt.status = okl_pkg::ST_OK;
              end else begin
                out_rsp_nxt.status = okl_pkg::ST_NOT_FOUND;
              end
            end
            okl_pkg::CMD_DUMP: begin
              out_valid_nxt = 1'b1;
              if (cnt_r == '0) begin
                out_rsp_nxt.status = okl_pkg::ST_EMPTY;
              end else begin
                ctl.rotate_en       = 1'b1;
                out_rsp_nxt.status  = okl_pkg::ST_OK;
                out_rsp_nxt.key_out = head_key;
                out_rsp_nxt.last    = cnt_r == CW'(1);
                idx_nxt             = CW'(1);
                if (cnt_r != CW'(1)) begin
                  state_nxt = okl_pkg::FSM_DUMP;
                end
              end
            end
            default: begin
              // unused code: no result, no change
            end
          endcase
        end
      end
      okl_pkg::FSM_DUMP: begin
        ctl.rotate_en       = 1'b1;
        out_valid_nxt       = 1'b1;
        out_rsp_nxt.status  = okl_pkg::ST_OK;
        out_rsp_nxt.key_out = head_key;
        out_rsp_nxt.last    = idx_r == (cnt_r - CW'(1));
        idx_nxt             = idx_r + CW'(1);
        if (out_rsp_nxt.last) begin
          state_nxt = okl_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = okl_pkg::FSM_IDLE;
      end
    endcase

    out_rsp_nxt.length = okl_pkg::LEN_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= okl_pkg::FSM_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = state_r == okl_pkg::FSM_DUMP;
  assign cnt       = cnt_r;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `OKL_ASSERT(a_cnt_bound, cnt_r <= CW'(DEPTH), "fill count above depth")
  `OKL_ASSERT(a_dump_nonempty, busy |-> (cnt_r > CW'(1)), "dump pass on short list")
  `OKL_ASSERT_NEXT(a_dump_cnt_hold, busy, $stable(cnt_r), "fill count moved during dump")
  `OKL_ASSERT_NEXT(a_req_result, accept && known_cmd, out_valid_r, "request gave no result")

endmodule

// ===== test/ordered_key_list_append_delete_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_key_list_append_delete_test
// Drives append, delete, dump and unused commands into the key list with
// random gaps between requests. A local copy of the list predicts every result.
// Each strobed result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ordered_key_list_append_delete_test;

  localparam int          LIST_DEPTH  = 16;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_WAIT  = LIST_DEPTH + 8;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic signed [okl_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [okl_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  okl_pkg::in_req_t  in_req;
  logic              out_valid;
  okl_pkg::out_rsp_t out_rsp;

  // local copy of the list
  logic signed [okl_pkg::KEY_W-1:0] list_keys [LIST_DEPTH];
  int                               list_fill;
  okl_pkg::out_rsp_t                pending_results [$];

  int   error_count;
  int   cycle_count;
  bit   no_idle;
  logic signed [okl_pkg::KEY_W-1:0] key_pool [8];

  ordered_key_list_append_delete #(
    .DEPTH(LIST_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // works out the results of one accepted request and updates the list copy
  task automatic predict_list_step(input logic [1:0] cmd,
                                   input logic signed [okl_pkg::KEY_W-1:0] key);
    okl_pkg::out_rsp_t r;
    int                pos;
    r      = '0;
    r.last = 1'b1;
    pos    = -1;
    case (cmd)
      okl_pkg::CMD_APPEND: begin
        if (list_fill >= LIST_DEPTH) begin
          r.status = okl_pkg::ST_FULL;
        end else begin
          list_keys[list_fill] = key;
          list_fill++;
          r.status = okl_pkg::ST_OK;
        end
        r.length = okl_pkg::LEN_W'(list_fill);
        pending_results.push_back(r);
      end
      okl_pkg::CMD_DELETE: begin
        for (int i = 0; i < list_fill; i++) begin
          if (pos < 0 && list_keys[i] == key) pos = i;
        end
        if (pos < 0) begin
          r.status = okl_pkg::ST_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < list_fill; i++) list_keys[i] = list_keys[i + 1];
          list_fill--;
          r.status = okl_pkg::ST_OK;
        end
        r.length = okl_pkg::LEN_W'(list_fill);
        pending_results.push_back(r);
      end
      okl_pkg::CMD_DUMP: begin
        r.length = okl_pkg::LEN_W'(list_fill);
        if (list_fill == 0) begin
          r.status = okl_pkg::ST_EMPTY;
          pending_results.push_back(r);
        end else begin
          for (int i = 0; i < list_fill; i++) begin
            r.status  = okl_pkg::ST_OK;
            r.key_out = list_keys[i];
            r.last    = (i + 1 == list_fill);
            pending_results.push_back(r);
          end
        end
      end
      default: ;  // unused code, nothing happens
    endcase
  endtask

  // one request: random gap, then hold start until the block takes it
  task automatic send_request(input logic [1:0] cmd,
                              input logic signed [okl_pkg::KEY_W-1:0] key);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          = 1'b1;
    in_req.command = cmd;
    in_req.key_in  = key;
    do @(posedge clk); while (busy);
    predict_list_step(cmd, key);
  endtask

  always @(posedge clk) begin
    okl_pkg::out_rsp_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: status=%0d key=%0d last=%0b length=%0d",
                   out_rsp.status, out_rsp.key_out, out_rsp.last, out_rsp.length);
      end else begin
        want = pending_results.pop_front();
        if (out_rsp.status !== want.status || out_rsp.key_out !== want.key_out ||
            out_rsp.last !== want.last || out_rsp.length !== want.length) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: exp status=%0d key=%0d last=%0b length=%0d",
                     want.status, want.key_out, want.last, want.length);
            $display("          got status=%0d key=%0d last=%0b length=%0d",
                     out_rsp.status, out_rsp.key_out, out_rsp.last, out_rsp.length);
          end
        end
      end
    end
  end

  function automatic logic signed [okl_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 6) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // delete keys mostly hit a held entry so head, middle and tail all go
  function automatic logic signed [okl_pkg::KEY_W-1:0] pick_delete_key();
    if (list_fill > 0 && $urandom_range(0, 9) < 7)
      return list_keys[$urandom_range(0, list_fill - 1)];
    return pick_key();
  endfunction

  task automatic test_empty_list();
    send_request(okl_pkg::CMD_DUMP, 32'sd0);
    send_request(okl_pkg::CMD_DELETE, KEY_MAX);
    send_request(CMD_UNUSED, KEY_MIN);
  endtask

  task automatic test_edit_order();
    send_request(okl_pkg::CMD_APPEND, KEY_MIN);
    send_request(okl_pkg::CMD_APPEND, KEY_MAX);
    send_request(okl_pkg::CMD_APPEND, 32'sd0);
    send_request(okl_pkg::CMD_APPEND, KEY_MAX);
    send_request(okl_pkg::CMD_APPEND, -32'sd1);
    send_request(okl_pkg::CMD_DUMP, $urandom);
    send_request(CMD_UNUSED, -32'sd1);
    // first of two equal keys goes, from the middle
    send_request(okl_pkg::CMD_DELETE, KEY_MAX);
    send_request(okl_pkg::CMD_DELETE, KEY_MIN);
    send_request(okl_pkg::CMD_DELETE, -32'sd1);
    send_request(okl_pkg::CMD_DELETE, 32'sd5);
    send_request(okl_pkg::CMD_DUMP, 32'sd0);
    send_request(okl_pkg::CMD_DELETE, KEY_MAX);
    // only entry left
    send_request(okl_pkg::CMD_DELETE, 32'sd0);
    send_request(okl_pkg::CMD_DUMP, KEY_MAX);
  endtask

  // fill up, bounce off the full list, dump all of it, then drain a few
  task automatic test_full_list();
    no_idle = 1'b1;
    while (list_fill < LIST_DEPTH) send_request(okl_pkg::CMD_APPEND, pick_key());
    no_idle = 1'b0;
    send_request(okl_pkg::CMD_APPEND, pick_key());
    send_request(okl_pkg::CMD_APPEND, $urandom);
    send_request(okl_pkg::CMD_DUMP, $urandom);
    send_request(okl_pkg::CMD_DELETE, list_keys[LIST_DEPTH - 1]);
    send_request(okl_pkg::CMD_DELETE, list_keys[0]);
  endtask

  task automatic test_random_traffic(input int n_items);
    bit grow;
    int pick;
    grow = 1'b0;
    for (int n = 0; n < n_items; n++) begin
      if (n % 20 == 0) begin
        grow    = ~grow;
        no_idle = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3)
        send_request(CMD_UNUSED, $urandom);
      else if (pick < 13)
        send_request(okl_pkg::CMD_DUMP, $urandom);
      else if ((pick < 78) == grow)
        send_request(okl_pkg::CMD_APPEND, pick_key());
      else
        send_request(okl_pkg::CMD_DELETE, pick_delete_key());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req      = '0;
    list_fill   = 0;
    error_count = 0;
    cycle_count = 0;
    no_idle     = 1'b0;
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 32'sd0;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_edit_order();
    test_full_list();
    test_random_traffic(140);

    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/okl_pkg.sv
src/okl_cell.sv
src/okl_ctrl.sv
src/ordered_key_list_append_delete.sv
test/ordered_key_list_append_delete_test.sv
